FILE: sv/lcg48_pkg.sv
// Shared types and constants for the 48-bit LCG random number block.
package lcg48_pkg;

	localparam int STATE_W = 48;
	localparam int MULT_W  = 35;
	localparam int DRAW_W  = 31;
	localparam int VALUE_W = 32;
	localparam int BITS_W  = 6;

	localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0] LCG_INC  = 48'hB;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_PICK,
		ST_DIV,
		ST_CHECK,
		ST_HOLD
	} ctrl_state_t;

	typedef enum logic {
		ACT_RAW     = 1'b0,
		ACT_BOUNDED = 1'b1
	} action_t;

	// requests from the sequencer to the advance unit
	typedef struct packed {
		logic load;
		logic start;
	} adv_ctl_t;

endpackage

FILE: sv/lcg48_adv.sv
// Generator state register and its bit-serial multiply-add advance unit.
module lcg48_adv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lcg48_pkg::adv_ctl_t               ctl,
	input  logic [lcg48_pkg::STATE_W-1:0]     seed,
	output logic [lcg48_pkg::STATE_W-1:0]     lcg_state,
	output logic                              done
);

	localparam logic [lcg48_pkg::STATE_W-1:0] STATE_W_RESET =
		{{(lcg48_pkg::STATE_W-lcg48_pkg::MULT_W){1'b0}}, lcg48_pkg::LCG_MULT};

	logic [lcg48_pkg::STATE_W-1:0] state_q;
	logic [lcg48_pkg::STATE_W-1:0] acc_q;
	logic [lcg48_pkg::STATE_W-1:0] acc_n;
	logic [5:0]                    cnt_q;
	logic                          busy_q;

	// one multiplier bit per cycle, most significant first
	always_comb begin
		acc_n = {acc_q[lcg48_pkg::STATE_W-2:0], 1'b0}
			+ (lcg48_pkg::LCG_MULT[cnt_q] ? state_q : '0);
	end

	assign done      = busy_q && (cnt_q == '0);
	assign lcg_state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_W_RESET;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (ctl.load) begin
				state_q <= seed ^ {{(lcg48_pkg::STATE_W-lcg48_pkg::MULT_W){1'b0}},
					lcg48_pkg::LCG_MULT};
			end else if (done) begin
				state_q <= acc_n + lcg48_pkg::LCG_INC;
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(lcg48_pkg::MULT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_n;
		end
	end

endmodule

FILE: sv/lcg48_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
module lcg48_rem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lcg48_pkg::DRAW_W-1:0]     dividend,
	input  logic [lcg48_pkg::DRAW_W-1:0]     divisor,
	output logic [lcg48_pkg::DRAW_W-1:0]     rem,
	output logic                             done
);

	logic [lcg48_pkg::DRAW_W-1:0] dvd_q;
	logic [lcg48_pkg::DRAW_W-1:0] rem_q;
	logic [lcg48_pkg::DRAW_W:0]   trial;
	logic [lcg48_pkg::DRAW_W:0]   diff;
	logic [4:0]                   cnt_q;
	logic                         busy_q;

	always_comb begin
		trial = {rem_q, dvd_q[lcg48_pkg::DRAW_W-1]};
		diff  = trial - {1'b0, divisor};
	end

	assign done = busy_q && (cnt_q == '0);
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(lcg48_pkg::DRAW_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lcg48_pkg::DRAW_W-2:0], 1'b0};
			// subtract when the partial remainder reaches the divisor
			rem_q <= diff[lcg48_pkg::DRAW_W] ? trial[lcg48_pkg::DRAW_W-1:0]
				: diff[lcg48_pkg::DRAW_W-1:0];
		end
	end

endmodule

FILE: sv/lcg48_bounded_random.sv
// Top level of the 48-bit LCG random number block with raw and bounded draws.
// Each request advances a 48-bit LCG (x*0x5DEECE66D+0xB mod 2^48) with a bit-serial
// multiply. A raw draw, and a bounded draw whose bound is zero or a power of two,
// takes its value from the advanced state; other bounds add a serial remainder and a
// rejection test, and a rejected attempt redraws and repeats both units. Writing the
// seed reloads the state at once; the seed channel and the request channel are ready
// only when the block is idle. A finished value waits in the output register while the
// next request is taken.
module lcg48_bounded_random (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [lcg48_pkg::BITS_W-1:0]      draw_bits,
	input  logic [lcg48_pkg::DRAW_W-1:0]      bound,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lcg48_pkg::VALUE_W-1:0]     value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcg48_pkg::STATE_W-1:0]     seed
);

	lcg48_pkg::ctrl_state_t        state_q, state_n;
	lcg48_pkg::adv_ctl_t           adv_ctl;
	lcg48_pkg::action_t            action_q;
	logic [lcg48_pkg::BITS_W-1:0]  bits_q;
	logic [lcg48_pkg::DRAW_W-1:0]  bound_q;
	logic [lcg48_pkg::DRAW_W-1:0]  u_q;
	logic [lcg48_pkg::VALUE_W-1:0] res_q;
	logic [lcg48_pkg::VALUE_W-1:0] res_d;
	logic [lcg48_pkg::VALUE_W-1:0] value_q;
	logic                          out_valid_q;

	logic [lcg48_pkg::STATE_W-1:0] lcg_state;
	logic                          adv_done;
	logic [lcg48_pkg::DRAW_W-1:0]  rem;
	logic                          rem_done;
	logic                          rem_start;

	logic                          in_fire;
	logic                          res_load;
	logic                          out_load;
	logic                          is_pow2;
	logic                          reject;
	logic [lcg48_pkg::DRAW_W-1:0]  r;
	logic [lcg48_pkg::VALUE_W-1:0] m;
	logic [lcg48_pkg::VALUE_W-1:0] t;
	logic [lcg48_pkg::VALUE_W-1:0] raw_val;
	logic [lcg48_pkg::VALUE_W-1:0] pow_val;
	logic [lcg48_pkg::BITS_W-1:0]  eff_bits;
	logic [lcg48_pkg::BITS_W-1:0]  shamt;
	logic [lcg48_pkg::STATE_W-1:0] shifted;

	lcg48_adv u_adv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (adv_ctl),
		.seed      (seed),
		.lcg_state (lcg_state),
		.done      (adv_done)
	);

	lcg48_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (r),
		.divisor  (bound_q),
		.rem      (rem),
		.done     (rem_done)
	);

	assign in_fire = in_valid && in_ready;

	// datapath for the draw decisions
	always_comb begin
		r        = lcg_state[lcg48_pkg::STATE_W-1 -: lcg48_pkg::DRAW_W];
		m        = {1'b0, bound_q} - 32'd1;
		is_pow2  = (({1'b0, bound_q} & m) == '0);
		t        = {1'b0, u_q} - {1'b0, rem} + m;
		reject   = t[lcg48_pkg::VALUE_W-1];
		eff_bits = (bits_q > 6'(lcg48_pkg::STATE_W)) ? 6'(lcg48_pkg::STATE_W) : bits_q;
		shamt    = 6'(lcg48_pkg::STATE_W) - eff_bits;
		shifted  = lcg_state >> shamt;
		raw_val  = (eff_bits == '0) ? '0 : shifted[lcg48_pkg::VALUE_W-1:0];
		pow_val  = '0;
		for (int k = 0; k < lcg48_pkg::DRAW_W; k++) begin
			if (bound_q[k]) begin
				pow_val = pow_val | ({1'b0, r} >> (lcg48_pkg::DRAW_W - k));
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lcg48_pkg::ST_IDLE: begin
				if (in_fire) state_n = lcg48_pkg::ST_ADV;
			end
			lcg48_pkg::ST_ADV: begin
				if (adv_done) state_n = lcg48_pkg::ST_PICK;
			end
			lcg48_pkg::ST_PICK: begin
				if (action_q == lcg48_pkg::ACT_RAW || is_pow2) begin
					state_n = lcg48_pkg::ST_HOLD;
				end else begin
					state_n = lcg48_pkg::ST_DIV;
				end
			end
			lcg48_pkg::ST_DIV: begin
				if (rem_done) state_n = lcg48_pkg::ST_CHECK;
			end
			lcg48_pkg::ST_CHECK: begin
				state_n = reject ? lcg48_pkg::ST_ADV : lcg48_pkg::ST_HOLD;
			end
			lcg48_pkg::ST_HOLD: begin
				if (!out_valid_q || out_ready) state_n = lcg48_pkg::ST_IDLE;
			end
			default: state_n = lcg48_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready      = 1'b0;
		cfg_ready     = 1'b0;
		adv_ctl.load  = 1'b0;
		adv_ctl.start = 1'b0;
		rem_start     = 1'b0;
		res_load      = 1'b0;
		res_d         = raw_val;
		out_load      = 1'b0;
		unique case (state_q)
			lcg48_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cfg_ready     = 1'b1;
				adv_ctl.load  = cfg_valid;
				adv_ctl.start = in_valid;
			end
			lcg48_pkg::ST_ADV: begin
			end
			lcg48_pkg::ST_PICK: begin
				if (action_q == lcg48_pkg::ACT_RAW) begin
					res_load = 1'b1;
				end else if (is_pow2) begin
					res_load = 1'b1;
					res_d    = pow_val;
				end else begin
					rem_start = 1'b1;
				end
			end
			lcg48_pkg::ST_DIV: begin
			end
			lcg48_pkg::ST_CHECK: begin
				// redraw while the draw falls in the biased top range
				if (reject) begin
					adv_ctl.start = 1'b1;
				end else begin
					res_load = 1'b1;
					res_d    = {1'b0, rem};
				end
			end
			lcg48_pkg::ST_HOLD: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcg48_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= lcg48_pkg::action_t'(action);
			bits_q   <= draw_bits;
			bound_q  <= bound;
		end
		if (rem_start) begin
			u_q <= r;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			value_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

FILE: sv/lcg48_chk.sv
// Port-level checker for the LCG random number block, bound to the top level.
module lcg48_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [lcg48_pkg::VALUE_W-1:0]     value,
	input logic                              cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result changed or dropped while stalled");

	// a taken request keeps the block busy for the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while the previous one still runs");

	// a new result appears only at the end of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in progress");

	// seed writes and requests open together
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == in_ready)
		else $error("seed port ready outside idle");

endmodule

bind lcg48_bounded_random lcg48_chk u_lcg48_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.cfg_ready (cfg_ready)
);

FILE: dv/lcg48_bounded_random_tb.sv
// Testbench for lcg48_bounded_random: queued raw and bounded draws against an LCG predictor.
module lcg48_bounded_random_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 235;
	localparam int MAX_PRINTS  = 40;

	typedef enum logic [1:0] {
		REQ_DRAW,
		REQ_SEED,
		REQ_DRAIN
	} req_kind_t;

	typedef struct {
		req_kind_t                      kind;
		lcg48_pkg::action_t             act;
		logic [lcg48_pkg::BITS_W-1:0]   nbits;
		logic [lcg48_pkg::DRAW_W-1:0]   lim;
		logic [lcg48_pkg::STATE_W-1:0]  seed_val;
		int                             gap;
	} req_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic                            action;
	logic [lcg48_pkg::BITS_W-1:0]    draw_bits;
	logic [lcg48_pkg::DRAW_W-1:0]    bound;
	logic                            out_valid;
	logic                            out_ready;
	logic [lcg48_pkg::VALUE_W-1:0]   value;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lcg48_pkg::STATE_W-1:0]   seed;

	req_t                            req_q[$];
	req_t                            cur;
	logic [lcg48_pkg::VALUE_W-1:0]   exp_value_q[$];
	logic [lcg48_pkg::VALUE_W-1:0]   want;
	logic [lcg48_pkg::STATE_W-1:0]   gen_state;

	int n_req_sent, n_req_taken, n_seed_sent, n_seed_taken;
	int n_value_seen, n_value_ack;
	int n_raw, n_bnd, n_redraw;
	int err_count, cycle_count;
	int tx_gap, rx_stall;
	bit rx_calm, res_shown;

	lcg48_bounded_random u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.draw_bits (draw_bits),
		.bound     (bound),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.seed      (seed)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTS) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		err_count++;
	endtask

	// advance the generator and return its top nb bits, capped at 48 and cut to the low 32
	function automatic logic [lcg48_pkg::VALUE_W-1:0] next_bits(input int unsigned nb);
		int unsigned                     k;
		logic [lcg48_pkg::STATE_W-1:0]   sh;
		gen_state = gen_state * lcg48_pkg::LCG_MULT + lcg48_pkg::LCG_INC;
		if (nb == 0) begin
			return '0;
		end
		k  = (nb > lcg48_pkg::STATE_W) ? lcg48_pkg::STATE_W : nb;
		sh = gen_state >> (lcg48_pkg::STATE_W - k);
		return sh[lcg48_pkg::VALUE_W-1:0];
	endfunction

	function automatic logic [lcg48_pkg::VALUE_W-1:0] bounded_value(
			input logic [lcg48_pkg::DRAW_W-1:0] lim);
		logic [63:0] b, r, u, m, t;
		b = 64'(lim);
		r = 64'(next_bits(lcg48_pkg::DRAW_W));
		m = (b - 64'd1) & 64'hFFFF_FFFF;
		// power of two, and zero, scale instead of taking a remainder
		if ((b & m) == 64'd0) begin
			t = (b * r) >> lcg48_pkg::DRAW_W;
			return t[lcg48_pkg::VALUE_W-1:0];
		end
		u = r;
		forever begin
			r = u % b;
			t = (u - r + m) & 64'hFFFF_FFFF;
			if (!t[31]) begin
				break;
			end
			u = 64'(next_bits(lcg48_pkg::DRAW_W));
			n_redraw++;
		end
		return r[lcg48_pkg::VALUE_W-1:0];
	endfunction

	task automatic queue_draw(input lcg48_pkg::action_t a,
			input logic [lcg48_pkg::BITS_W-1:0] nb,
			input logic [lcg48_pkg::DRAW_W-1:0] lim, input int gap);
		req_t it;
		it.kind     = REQ_DRAW;
		it.act      = a;
		it.nbits    = nb;
		it.lim      = lim;
		it.seed_val = '0;
		it.gap      = gap;
		req_q.push_back(it);
	endtask

	task automatic queue_ctl(input req_kind_t kind, input logic [lcg48_pkg::STATE_W-1:0] s);
		req_t it;
		it.kind     = kind;
		it.act      = lcg48_pkg::ACT_RAW;
		it.nbits    = '0;
		it.lim      = '0;
		it.seed_val = s;
		it.gap      = $urandom_range(0, 11);
		req_q.push_back(it);
	endtask

	function automatic logic [lcg48_pkg::DRAW_W-1:0] pick_bound();
		unique case ($urandom_range(0, 7))
			0: return lcg48_pkg::DRAW_W'(1) << $urandom_range(0, lcg48_pkg::DRAW_W - 1);
			1: return lcg48_pkg::DRAW_W'($urandom_range(1, 1000));
			// just above 2^30 the rejection rate is near one half
			2: return lcg48_pkg::DRAW_W'((1 << 30) + $urandom_range(1, 1 << 29));
			3: return lcg48_pkg::DRAW_W'($urandom_range(0, 3));
			default: return lcg48_pkg::DRAW_W'($urandom);
		endcase
	endfunction

	// driver: one request or seed write in flight at a time
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_req_sent != n_req_taken || n_seed_sent != n_seed_taken) begin
				// hold until taken
			end else if (tx_gap != 0) begin
				in_valid  <= 1'b0;
				cfg_valid <= 1'b0;
				tx_gap--;
			end else if (req_q.size() == 0) begin
				in_valid  <= 1'b0;
				cfg_valid <= 1'b0;
			end else begin
				cur = req_q[0];
				if (cur.kind == REQ_DRAW) begin
					in_valid  <= 1'b1;
					cfg_valid <= 1'b0;
					action    <= cur.act;
					draw_bits <= cur.nbits;
					bound     <= cur.lim;
					tx_gap = cur.gap;
					n_req_sent++;
					void'(req_q.pop_front());
				end else begin
					in_valid <= 1'b0;
					// seed writes and drains wait for every outstanding result
					if (exp_value_q.size() == 0) begin
						if (cur.kind == REQ_SEED) begin
							cfg_valid <= 1'b1;
							seed      <= cur.seed_val;
							n_seed_sent++;
						end else begin
							cfg_valid <= 1'b0;
						end
						tx_gap = cur.gap;
						void'(req_q.pop_front());
					end else begin
						cfg_valid <= 1'b0;
					end
				end
			end
		end
	end

	// result side back-pressure, counted while a result is waiting
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_value_seen != n_value_ack) begin
				n_value_ack = n_value_seen;
				if ($urandom_range(0, 39) == 0) begin
					rx_calm = !rx_calm;
				end
				rx_stall = rx_calm ? 0 : $urandom_range(0, 11);
			end
			if (rx_stall != 0) begin
				out_ready <= 1'b0;
				if (res_shown) begin
					rx_stall--;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check results, then predict for newly taken requests
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			res_shown = out_valid && !out_ready;
			if (out_valid && out_ready) begin
				n_value_seen++;
				if (exp_value_q.size() == 0) begin
					report_mismatch($sformatf("value 0x%08h with no request waiting", value));
				end else begin
					want = exp_value_q.pop_front();
					if (value !== want) begin
						report_mismatch($sformatf("value 0x%08h, expected 0x%08h",
							value, want));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				gen_state = seed ^ lcg48_pkg::STATE_W'(lcg48_pkg::LCG_MULT);
				n_seed_taken++;
			end
			if (in_valid && in_ready) begin
				if (action == lcg48_pkg::ACT_RAW) begin
					exp_value_q.push_back(next_bits(draw_bits));
					n_raw++;
				end else begin
					exp_value_q.push_back(bounded_value(bound));
					n_bnd++;
				end
				n_req_taken++;
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [lcg48_pkg::STATE_W-1:0] phase_seed[N_PHASES];
		logic [lcg48_pkg::DRAW_W-1:0]  lim;
		lcg48_pkg::action_t            a;
		bit                            calm;

		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cfg_valid = 1'b0;
		out_ready = 1'b0;
		action    = lcg48_pkg::ACT_RAW;
		draw_bits = '0;
		bound     = '0;
		seed      = '0;
		gen_state = lcg48_pkg::STATE_W'(lcg48_pkg::LCG_MULT);

		// directed draws from the reset state
		queue_draw(lcg48_pkg::ACT_RAW, 6'd0,  31'h7FFF_FFFF, $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd1,  31'h0,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd16, pick_bound(),  $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd31, pick_bound(),  $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd32, 31'h7FFF_FFFF, $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd33, pick_bound(),  $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd47, pick_bound(),  $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd48, pick_bound(),  $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd49, pick_bound(),  $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_RAW, 6'd63, 31'h0,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd63, 31'd0,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd0,  31'd1,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd63, 31'd2,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd5,  31'd3,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd0,  31'd5,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd17, 31'd7,         $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd63, 31'd1000,      $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd0,  31'h4000_0000, $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd32, 31'h4000_0001, $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd1,  31'h5555_5555, $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd48, 31'h7FFF_FFFE, $urandom_range(0, 11));
		queue_draw(lcg48_pkg::ACT_BOUNDED, 6'd63, 31'h7FFF_FFFF, $urandom_range(0, 11));

		// the first seed zeroes the state, then the field extremes, then random seeds
		phase_seed[0] = lcg48_pkg::STATE_W'(lcg48_pkg::LCG_MULT);
		phase_seed[1] = '1;
		phase_seed[2] = '0;
		for (int p = 3; p < N_PHASES; p++) begin
			phase_seed[p] = lcg48_pkg::STATE_W'({$urandom, $urandom});
		end

		for (int p = 0; p < N_PHASES; p++) begin
			calm = (p == 2);
			queue_ctl(REQ_SEED, phase_seed[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) begin
					queue_ctl(REQ_DRAIN, '0);
				end
				a   = $urandom_range(0, 1) ? lcg48_pkg::ACT_BOUNDED : lcg48_pkg::ACT_RAW;
				lim = pick_bound();
				queue_draw(a,
					($urandom_range(0, 3) == 0)
						? lcg48_pkg::BITS_W'($urandom_range(0, 63))
						: lcg48_pkg::BITS_W'($urandom_range(1, 32)),
					lim, calm ? 0 : $urandom_range(0, 11));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || n_req_sent != n_req_taken ||
				n_seed_sent != n_seed_taken || exp_value_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);

		$display("checked %0d raw and %0d bounded draws across %0d seed loads",
			n_raw, n_bnd, n_seed_taken);
		$display("bounded draws were rejected and redrawn %0d times, %0d mismatches",
			n_redraw, err_count);
		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/lcg48_pkg.sv
sv/lcg48_adv.sv
sv/lcg48_rem.sv
sv/lcg48_bounded_random.sv
sv/lcg48_chk.sv
dv/lcg48_bounded_random_tb.sv
